// File: rtl/pmq_pkg.sv
// Shared types, sizes and helpers for the port mailbox queues.
`timescale 1ns / 1ps

package pmq_pkg;

  localparam int NUM_PORTS   = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int SLOT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int MEM_DEPTH = NUM_PORTS * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam int PORT_W   = 8;
  localparam int THREAD_W = 8;
  localparam int DATA_W   = 8;
  localparam int MSG_W    = THREAD_W + DATA_W;
  localparam int QCNT_W   = 5;

  typedef enum logic [1:0] {
    OP_LISTEN = 2'd0,
    OP_SEND   = 2'd1,
    OP_RECV   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNKNOWN    = 3'd1,
    ST_FULL       = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [PORT_W-1:0]   port_id;
    logic [THREAD_W-1:0] sender;
    logic [DATA_W-1:0]   data;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic                msg_valid;
    logic [THREAD_W-1:0] msg_sender;
    logic [DATA_W-1:0]   msg_data;
    logic [QCNT_W-1:0]   queue_count;
  } result_t;

  // Reported count keeps the low five bits only.
  function automatic logic [QCNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+QCNT_W-1:0] ext;
    ext = {{QCNT_W{1'b0}}, c};
    return ext[QCNT_W-1:0];
  endfunction

endpackage

// File: rtl/pmq_front.sv
// Front end: unpack incoming words and classify the operation.
`timescale 1ns / 1ps

module pmq_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  output logic               push_valid,
  input  logic               push_ready,
  output pmq_pkg::item_t     push_item
);

  pmq_pkg::op_t op;

  always_comb begin
    unique case (in_tuser)
      2'd0:    op = pmq_pkg::OP_LISTEN;
      2'd1:    op = pmq_pkg::OP_SEND;
      2'd2:    op = pmq_pkg::OP_RECV;
      default: op = pmq_pkg::OP_NOP;
    endcase
  end

  assign push_item.op      = op;
  assign push_item.port_id = in_tdata[7:0];
  assign push_item.sender  = in_tdata[15:8];
  assign push_item.data    = in_tdata[23:16];

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

// File: rtl/pmq_queue.sv
// Short queue of classified words between front end and mailbox engine.
`timescale 1ns / 1ps

module pmq_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pmq_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pmq_pkg::item_t pop_item
);

  pmq_pkg::item_t                   store_r [pmq_pkg::FIFO_DEPTH];
  logic [pmq_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [pmq_pkg::FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [pmq_pkg::FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign push_ready = (cnt_r != pmq_pkg::FIFO_CNT_W'(pmq_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == pmq_pkg::FIFO_PTR_W'(pmq_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pmq_pkg::FIFO_PTR_W'(pmq_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/pmq_back.sv
// Mailbox engine: port table, ring pointers, message memory and result register.
`timescale 1ns / 1ps

module pmq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  pmq_pkg::item_t   pop_item,
  output logic             out_valid,
  input  logic             out_ready,
  output pmq_pkg::result_t out_res
);

  typedef enum logic {S_EXEC, S_READ} state_t;

  state_t                          state_r;
  logic                            in_use_r   [pmq_pkg::NUM_PORTS];
  logic [pmq_pkg::PORT_W-1:0]      port_num_r [pmq_pkg::NUM_PORTS];
  logic [pmq_pkg::HEAD_W-1:0]      head_r     [pmq_pkg::NUM_PORTS];
  logic [pmq_pkg::CNT_W-1:0]       count_r    [pmq_pkg::NUM_PORTS];
  logic [pmq_pkg::MSG_W-1:0]       mem        [pmq_pkg::MEM_DEPTH];
  logic [pmq_pkg::MSG_W-1:0]       rd_data_r;
  logic                            out_valid_r;
  pmq_pkg::result_t                out_res_r;
  pmq_pkg::result_t                pend_r;

  logic                            found, have_free, take;
  logic [pmq_pkg::SLOT_W-1:0]      slot, free_slot;
  logic [pmq_pkg::HEAD_W-1:0]      cur_head, next_head;
  logic [pmq_pkg::CNT_W-1:0]       cur_cnt;
  logic [pmq_pkg::SUM_W-1:0]       tail_sum, tail_wrap;
  logic [pmq_pkg::HEAD_W-1:0]      pos;
  logic [pmq_pkg::ADDR_W-1:0]      mem_addr;
  logic                            mem_we;
  logic                            do_listen, do_send, do_recv;
  pmq_pkg::result_t                res;
  pmq_pkg::result_t                read_res;

  // Parallel port lookup and lowest free entry.
  always_comb begin
    found     = 1'b0;
    have_free = 1'b0;
    slot      = '0;
    free_slot = '0;
    for (int i = pmq_pkg::NUM_PORTS - 1; i >= 0; i--) begin
      if (in_use_r[i] && (port_num_r[i] == pop_item.port_id)) begin
        found = 1'b1;
        slot  = pmq_pkg::SLOT_W'(i);
      end
      if (!in_use_r[i]) begin
        have_free = 1'b1;
        free_slot = pmq_pkg::SLOT_W'(i);
      end
    end
  end

  assign cur_head  = head_r[slot];
  assign cur_cnt   = count_r[slot];
  assign tail_sum  = pmq_pkg::SUM_W'(cur_head) + pmq_pkg::SUM_W'(cur_cnt);
  assign tail_wrap = (tail_sum >= pmq_pkg::SUM_W'(pmq_pkg::QUEUE_DEPTH)) ?
                     tail_sum - pmq_pkg::SUM_W'(pmq_pkg::QUEUE_DEPTH) : tail_sum;
  assign next_head = (cur_head == pmq_pkg::HEAD_W'(pmq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : cur_head + 1'b1;

  always_comb begin
    pos      = tail_wrap[pmq_pkg::HEAD_W-1:0];
    if (pop_item.op == pmq_pkg::OP_RECV) begin
      pos = cur_head;
    end
    mem_addr = pmq_pkg::ADDR_W'(slot) * pmq_pkg::ADDR_W'(pmq_pkg::QUEUE_DEPTH)
             + pmq_pkg::ADDR_W'(pos);
  end

  assign take      = (state_r == S_EXEC) && pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = take;

  // Classify the outcome of the word at the head of the queue.
  always_comb begin
    res           = '0;
    res.status    = pmq_pkg::ST_OK;
    do_listen     = 1'b0;
    do_send       = 1'b0;
    do_recv       = 1'b0;
    unique case (pop_item.op)
      pmq_pkg::OP_LISTEN: begin
        if (found) begin
          res.queue_count = pmq_pkg::count_out(cur_cnt);
        end else if (!have_free) begin
          res.status = pmq_pkg::ST_TABLE_FULL;
        end else begin
          do_listen = 1'b1;
        end
      end
      pmq_pkg::OP_SEND: begin
        if (!found) begin
          res.status = pmq_pkg::ST_UNKNOWN;
        end else if (cur_cnt >= pmq_pkg::CNT_W'(pmq_pkg::QUEUE_DEPTH)) begin
          res.status      = pmq_pkg::ST_FULL;
          res.queue_count = pmq_pkg::count_out(cur_cnt);
        end else begin
          do_send         = 1'b1;
          res.queue_count = pmq_pkg::count_out(cur_cnt + 1'b1);
        end
      end
      pmq_pkg::OP_RECV: begin
        if (!found) begin
          res.status = pmq_pkg::ST_UNKNOWN;
        end else if (cur_cnt == '0) begin
          res.status = pmq_pkg::ST_EMPTY;
        end else begin
          do_recv         = 1'b1;
          res.msg_valid   = 1'b1;
          res.queue_count = pmq_pkg::count_out(cur_cnt - 1'b1);
        end
      end
      default: begin
        if (found) begin
          res.queue_count = pmq_pkg::count_out(cur_cnt);
        end
      end
    endcase
  end

  // Merge the message read out of the memory into the waiting receive result.
  always_comb begin
    read_res            = pend_r;
    read_res.msg_sender = rd_data_r[pmq_pkg::MSG_W-1:pmq_pkg::DATA_W];
    read_res.msg_data   = rd_data_r[pmq_pkg::DATA_W-1:0];
  end

  assign mem_we = take && do_send;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pmq_pkg::NUM_PORTS; i++) begin
        in_use_r[i] <= 1'b0;
        head_r[i]   <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      unique case (state_r)
        S_EXEC: begin
          if (take && !do_recv) begin
            out_valid_r <= 1'b1;
          end else if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (take) begin
            if (do_listen) begin
              in_use_r[free_slot] <= 1'b1;
              head_r[free_slot]   <= '0;
              count_r[free_slot]  <= '0;
            end
            if (do_send) begin
              count_r[slot] <= cur_cnt + 1'b1;
            end
            if (do_recv) begin
              head_r[slot]  <= next_head;
              count_r[slot] <= cur_cnt - 1'b1;
              state_r       <= S_READ;
            end
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          state_r     <= S_EXEC;
        end
        default: state_r <= S_EXEC;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take && do_listen) begin
      port_num_r[free_slot] <= pop_item.port_id;
    end
    if (take) begin
      pend_r    <= res;
      out_res_r <= res;
    end else if (state_r == S_READ) begin
      out_res_r <= read_res;
    end
  end

  // Message memory: up to one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {pop_item.sender, pop_item.data};
    end
    rd_data_r <= mem[mem_addr];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/port_mailbox_queues.sv
// Top level of the port mailbox queues: stream ports, front end, queue, engine.
`timescale 1ns / 1ps

// Mailbox engine with a table of 8 ports, each owning a 16-word ring of
// messages (source thread, data byte). Every input word carries an operation
// in in_tuser (0 listen, 1 send, 2 receive, 3 no-op) and yields exactly one
// result word carrying a status (ok, unknown port, queue full, queue empty,
// port table full), the received message if any, and the addressed port's
// queue count after the operation. New ports take the lowest free table
// entry and are never removed. Input words pass a two-word queue into the
// engine, so the input side keeps accepting while a result waits. The engine
// takes a new word whenever it is in S_EXEC and its result register is free
// or being taken; a receive that returns a message passes through S_READ for
// the registered read of the message memory. A result word is registered in
// the engine and presented on out_tdata. The message memory needs no clearing:
// only written entries are ever returned.
module port_mailbox_queues (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] port_id, [15:8] sender, [23:16] data, [31:24] zero
  input  logic [31:0] in_tdata,
  // [1:0] func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [3] msg_valid, [11:4] msg_sender, [19:12] msg_data,
  // [24:20] queue_count, [31:25] zero
  output logic [31:0] out_tdata
);

  logic             push_valid, push_ready;
  pmq_pkg::item_t   push_item;
  logic             pop_valid, pop_ready;
  pmq_pkg::item_t   pop_item;
  pmq_pkg::result_t res;

  // Unpack and classify the incoming word.
  pmq_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Hold words while the engine is busy.
  pmq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Carry out the operation and register the result word.
  pmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'd0, res.queue_count, res.msg_data, res.msg_sender,
                      res.msg_valid, res.status};

endmodule
